### rtl/ntr_pkg.sv
// Shared types, codes and constants for the nametable tile renderer.
package ntr_pkg;

    localparam int MEMORY_DEPTH_DEF  = 16384;
    localparam int PALETTE_DEPTH_DEF = 32;
    localparam int ADDR_W            = 14;
    localparam int CFG_W             = 2;

    localparam logic [1:0] OP_MEM_WR = 2'd0;
    localparam logic [1:0] OP_PAL_WR = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_GRAY   = 2'd1;
    localparam logic [1:0] MODE_ATTR   = 2'd2;

    localparam logic CFG_DISPLAY_MODE = 1'b0;
    localparam logic CFG_PATTERN_HIGH = 1'b1;

    // nametables sit at 0x2000 + 0x400 * select; attributes at offset 960 (0x3C0)
    localparam logic [1:0] NT_PREFIX = 2'b10;
    localparam logic [3:0] ATTR_ROWS = 4'hF;

    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] address;
        logic [31:0] data;
        logic [1:0]  nametable_select;
        logic [4:0]  tile_row;
        logic [4:0]  tile_column;
    } t_ntr_in;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [2:0]  pixel_x;
        logic [2:0]  pixel_y;
        logic        last_pixel;
    } t_ntr_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TILE,
        ST_ATTR,
        ST_SEL,
        ST_HI,
        ST_PIX
    } t_ntr_state;

    function automatic logic [31:0] gray_level(input logic [1:0] code);
        logic [31:0] level;
        case (code)
            2'd0:    level = 32'hFF00_0000;
            2'd1:    level = 32'hFF80_8080;
            2'd2:    level = 32'hFFC0_C0C0;
            default: level = 32'hFFFF_FFFF;
        endcase
        return level;
    endfunction

endpackage

### rtl/ntr_vram.sv
// Video memory: one write port, one registered read port, out-of-range reads give zero.
module ntr_vram #(
    parameter int DEPTH = ntr_pkg::MEMORY_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ntr_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic                      i_re,
    input  logic [ntr_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import ntr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [ADDR_W:0] DEPTH_L = (ADDR_W+1)'(DEPTH);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we && ({1'b0, i_waddr} < DEPTH_L)) begin
            r_mem[i_waddr[AW-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if ({1'b0, i_raddr} < DEPTH_L) begin
                r_rdata <= r_mem[i_raddr[AW-1:0]];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/nametable_tile_renderer_unit.sv
// Top level of the nametable tile renderer: sequencer, palette and pixel pipeline.
//
// Input channel (i_valid / o_stall) takes write beats and render beats. A memory or
// palette write beat is taken and gives no output. A render beat reads the tile
// index, the attribute byte and, per tile line, the low and high pattern bytes
// through the single video memory read port, then issues that line's 8 pixels one
// per cycle while the output does not stall. The block is busy for the whole
// render (setup reads, then per line a pattern read and that line's pixels), paced
// by the one read port. Output beats (o_valid / i_stall) carry one pixel each, 64
// per render in row order, leftmost first, last_pixel on the final one; the first
// pixel follows the setup reads. A palette read stage and an output register form
// a short pipe; a stall on the output freezes the pipe and the pixel issue, nothing
// is lost. Configuration is a plain write port, written while idle (not enforced
// by the block). Reset clears the sequencer, pipe valids and configuration; memory
// and palette contents are undefined until written.
module nametable_tile_renderer_unit #(
    parameter int MEMORY_DEPTH  = ntr_pkg::MEMORY_DEPTH_DEF,
    parameter int PALETTE_DEPTH = ntr_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  ntr_pkg::t_ntr_in         i_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output ntr_pkg::t_ntr_out        o_out,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [ntr_pkg::CFG_W-1:0] i_cfg_data
);
    import ntr_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam logic [ADDR_W:0] PAL_DEPTH_L = (ADDR_W+1)'(PALETTE_DEPTH);

    t_ntr_state r_state, n_state;

    logic [1:0]  r_display_mode;
    logic        r_pattern_high;
    logic [1:0]  r_sel;
    logic [4:0]  r_row;
    logic [4:0]  r_col;
    logic [7:0]  r_tile;
    logic [1:0]  r_pal_sel;
    logic [7:0]  r_lo;
    logic [2:0]  r_x, r_y;

    logic [31:0] r_palette [PALETTE_DEPTH];
    logic [31:0] r_pal_q;
    logic        r_a_valid;
    logic        r_a_gray;
    logic [1:0]  r_a_code;
    logic [2:0]  r_a_x, r_a_y;
    logic        r_a_last;
    logic        r_out_valid;
    t_ntr_out    r_out;

    logic              accept;
    logic              pipe_adv;
    logic              issue;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        mem_q;
    logic              mem_we;
    logic              lo_bit, hi_bit;
    logic [1:0]        code;
    logic [3:0]        pal_idx;
    logic              gray;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign pipe_adv = !(r_out_valid && i_stall);
    assign issue    = (r_state == ST_PIX) && pipe_adv;
    assign mem_we   = accept && (i_in.op == OP_MEM_WR);

    ntr_vram #(
        .DEPTH (MEMORY_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_in.address),
        .i_wdata (i_in.data[7:0]),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.op == OP_RENDER)) begin
                    n_state = ST_TILE;
                end
            end
            ST_TILE: begin
                rd_en   = 1'b1;
                rd_addr = {NT_PREFIX, r_sel, r_row, r_col};
                n_state = ST_ATTR;
            end
            ST_ATTR: begin
                rd_en   = 1'b1;
                rd_addr = {NT_PREFIX, r_sel, ATTR_ROWS, r_row[4:2], r_col[4:2]};
                n_state = ST_SEL;
            end
            ST_SEL: begin
                rd_en   = 1'b1;
                rd_addr = {1'b0, r_pattern_high, r_tile, 1'b0, r_y};
                n_state = ST_HI;
            end
            ST_HI: begin
                rd_en   = 1'b1;
                rd_addr = {1'b0, r_pattern_high, r_tile, 1'b1, r_y};
                n_state = ST_PIX;
            end
            ST_PIX: begin
                if (pipe_adv && (r_x == 3'd7)) begin
                    if (r_y == 3'd7) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {1'b0, r_pattern_high, r_tile, 1'b0, r_y + 3'd1};
                        n_state = ST_HI;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= MODE_NORMAL;
            r_pattern_high <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISPLAY_MODE: r_display_mode <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pattern_high <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.op == OP_RENDER)) begin
            r_sel <= i_in.nametable_select;
            r_row <= i_in.tile_row;
            r_col <= i_in.tile_column;
            r_x   <= '0;
            r_y   <= '0;
        end
        if (r_state == ST_ATTR) begin
            r_tile <= mem_q;
        end
        if (r_state == ST_SEL) begin
            case ({r_row[1], r_col[1]})
                2'b00:   r_pal_sel <= mem_q[1:0];
                2'b01:   r_pal_sel <= mem_q[3:2];
                2'b10:   r_pal_sel <= mem_q[5:4];
                default: r_pal_sel <= mem_q[7:6];
            endcase
        end
        if (r_state == ST_HI) begin
            r_lo <= mem_q;
        end
        if (issue) begin
            r_x <= r_x + 3'd1;
            if (r_x == 3'd7) begin
                r_y <= r_y + 3'd1;
            end
        end
    end

    // high plane byte stays in the read register for the whole line
    always_comb begin
        lo_bit = r_lo[~r_x];
        hi_bit = mem_q[~r_x];
        gray   = (r_display_mode == MODE_GRAY);
        if (r_display_mode == MODE_ATTR) begin
            code = {r_y[2], r_x[2]};
        end else begin
            code = {hi_bit, lo_bit};
        end
        if (code == 2'd0) begin
            pal_idx = '0;
        end else begin
            pal_idx = {r_pal_sel, code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.op == OP_PAL_WR) && ({1'b0, i_in.address} < PAL_DEPTH_L)) begin
            r_palette[i_in.address[PAL_AW-1:0]] <= i_in.data;
        end
        if (issue) begin
            r_pal_q <= r_palette[PAL_AW'(pal_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_adv) begin
            r_a_valid   <= issue;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_gray <= gray;
            r_a_code <= code;
            r_a_x    <= r_x;
            r_a_y    <= r_y;
            r_a_last <= (r_x == 3'd7) && (r_y == 3'd7);
        end
        if (pipe_adv && r_a_valid) begin
            r_out.pixel_color <= r_a_gray ? gray_level(r_a_code) : r_pal_q;
            r_out.pixel_x     <= r_a_x;
            r_out.pixel_y     <= r_a_y;
            r_out.last_pixel  <= r_a_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_render_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.op == OP_RENDER)) |=> (r_state == ST_TILE))
        else $error("render beat did not start the fetch sequence");

    a_tile_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && (r_x == 3'd7) && (r_y == 3'd7)) |=> (r_state == ST_IDLE))
        else $error("sequencer not idle after final pixel");

    a_pipe_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && pipe_adv) |=> o_valid)
        else $error("pixel lost between palette stage and output");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last_pixel) |-> ((o_out.pixel_x == 3'd7) && (o_out.pixel_y == 3'd7)))
        else $error("last pixel flag on wrong position");

    a_no_issue_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PIX && !pipe_adv) |=> $stable(r_x) && $stable(r_y))
        else $error("pixel counters moved under output stall");

endmodule

### test/nametable_tile_renderer_unit_test.sv
// Testbench for the nametable tile renderer: directed table, then checked random phases.
module nametable_tile_renderer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ntr_pkg::*;

    localparam int MEM_DEPTH    = MEMORY_DEPTH_DEF;
    localparam int PAL_DEPTH    = PALETTE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_BEATS  = 47;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [3:0][31:0] GRAY_ARGB = {
        32'hFFFF_FFFF, 32'hFFC0_C0C0, 32'hFF80_8080, 32'hFF00_0000
    };
    localparam logic [1:0] PHASE_MODE [NUM_PHASES] = '{
        MODE_GRAY, MODE_ATTR, MODE_NORMAL, MODE_SPARE, MODE_ATTR, MODE_GRAY, MODE_NORMAL
    };
    localparam bit [0:NUM_PHASES-1] PHASE_PTH = 7'b1011001;

    typedef struct packed {
        bit          is_cfg;
        logic        cfg_index;
        logic [1:0]  cfg_value;
        logic [4:0]  count;
        t_ntr_in     beat;
        bit          typed;
        logic [31:0] color;
    } t_step;

    localparam int NUM_STEPS = 22;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_valid     = 1'b0;
    logic     o_stall;
    t_ntr_in  i_in        = '0;
    logic     o_valid;
    logic     i_stall     = 1'b0;
    t_ntr_out o_out;
    logic     i_cfg_we    = 1'b0;
    logic     i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [7:0]  vram_q [MEM_DEPTH];
    bit          vram_ok [MEM_DEPTH];
    logic [31:0] pal_q [PAL_DEPTH];
    bit          pal_ok [PAL_DEPTH];
    logic [1:0]  mode_q = MODE_NORMAL;
    logic        pth_q  = 1'b0;

    t_ntr_out pixel_q [$];
    t_ntr_out pixel_want;
    t_step    directed_steps [NUM_STEPS];
    logic [7:0] tile_pool [4];

    int beats_taken   = 0;
    int rx_hold_cycles = 0;
    bit quiet  = 1'b0;
    bit failed = 1'b0;

    nametable_tile_renderer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void nametable_addrs(input logic [1:0] sel, input logic [4:0] row,
                                            input logic [4:0] col, output int nt_addr,
                                            output int at_addr, output int at_shift);
        nt_addr  = 'h2000 + 'h400 * int'(sel) + 32 * int'(row) + int'(col);
        at_addr  = 'h2000 + 'h400 * int'(sel) + 960 + 2 * int'(row & 5'h1C) + int'(col >> 2);
        at_shift = int'(col & 5'd2) | (int'(row & 5'd2) << 1);
    endfunction

    function automatic logic [31:0] palette_argb(input int idx);
        return pal_q[(idx % 4 == 0) ? 0 : idx];
    endfunction

    function automatic void queue_tile_pixels(input t_ntr_in beat, input bit typed,
                                              input logic [31:0] typed_color);
        int nt_addr, at_addr, at_shift, pat_addr, pal_base, code;
        logic [7:0] lo, hi;
        t_ntr_out px;
        nametable_addrs(beat.nametable_select, beat.tile_row, beat.tile_column,
                        nt_addr, at_addr, at_shift);
        pal_base = 4 * int'((vram_q[at_addr] >> at_shift) & 8'd3);
        pat_addr = (pth_q ? 'h1000 : 0) + 16 * int'(vram_q[nt_addr]);
        for (int y = 0; y < 8; y++) begin
            lo = vram_q[pat_addr + y];
            hi = vram_q[pat_addr + y + 8];
            for (int x = 0; x < 8; x++) begin
                if (mode_q == MODE_ATTR) begin
                    code = x / 4 + 2 * (y / 4);
                end else begin
                    code = int'({hi[7 - x], lo[7 - x]});
                end
                if (typed) begin
                    px.pixel_color = typed_color;
                end else if (mode_q == MODE_GRAY) begin
                    px.pixel_color = GRAY_ARGB[code];
                end else begin
                    px.pixel_color = palette_argb(pal_base + code);
                end
                px.pixel_x    = 3'(x);
                px.pixel_y    = 3'(y);
                px.last_pixel = (x == 7 && y == 7);
                pixel_q.push_back(px);
            end
        end
    endfunction

    function automatic void take_beat(input t_ntr_in beat, input bit typed,
                                      input logic [31:0] typed_color);
        case (beat.op)
            OP_MEM_WR: begin
                vram_q[beat.address]  = beat.data[7:0];
                vram_ok[beat.address] = 1'b1;
                beats_taken++;
            end
            OP_PAL_WR: begin
                if (int'(beat.address) < PAL_DEPTH) begin
                    pal_q[beat.address[4:0]]  = beat.data;
                    pal_ok[beat.address[4:0]] = 1'b1;
                    beats_taken++;
                end
            end
            OP_RENDER: begin
                queue_tile_pixels(beat, typed, typed_color);
                beats_taken++;
            end
            default: ;
        endcase
    endfunction

    function automatic t_ntr_in junk_beat(input logic [1:0] op, input logic [13:0] address,
                                          input logic [31:0] data);
        t_ntr_in beat;
        beat.op               = op;
        beat.address          = address;
        beat.data             = data;
        beat.nametable_select = 2'($urandom);
        beat.tile_row         = 5'($urandom);
        beat.tile_column      = 5'($urandom);
        return beat;
    endfunction

    function automatic t_step row_beat(input logic [1:0] op, input logic [13:0] address,
                                       input logic [31:0] data, input logic [1:0] sel,
                                       input logic [4:0] row, input logic [4:0] col,
                                       input logic [4:0] count, input bit typed,
                                       input logic [31:0] color);
        t_step s;
        s = '0;
        s.beat.op               = op;
        s.beat.address          = address;
        s.beat.data             = data;
        s.beat.nametable_select = sel;
        s.beat.tile_row         = row;
        s.beat.tile_column      = col;
        s.count                 = count;
        s.typed                 = typed;
        s.color                 = color;
        return s;
    endfunction

    function automatic t_step row_cfg(input logic index, input logic [1:0] value);
        t_step s;
        s = '0;
        s.is_cfg    = 1'b1;
        s.cfg_index = index;
        s.cfg_value = value;
        return s;
    endfunction

    task automatic send_beat(input t_ntr_in beat, input bit typed, input logic [31:0] typed_color);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_in    <= beat;
        do @(posedge i_clk); while (o_stall);
        take_beat(beat, typed, typed_color);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic index, input logic [1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (index == CFG_DISPLAY_MODE) begin
            mode_q = value;
        end else begin
            pth_q = value[0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // writes whatever the tile still lacks, then renders it
    task automatic render_sequence();
        logic [1:0] sel;
        logic [4:0] row, col;
        int nt_addr, at_addr, at_shift, pat_addr, pal_base, idx;
        t_ntr_in beat;
        sel = 2'($urandom);
        row = 5'($urandom);
        col = 5'($urandom);
        nametable_addrs(sel, row, col, nt_addr, at_addr, at_shift);
        if (!vram_ok[nt_addr] || $urandom_range(0, 7) == 0) begin
            send_beat(junk_beat(OP_MEM_WR, 14'(nt_addr),
                                {24'($urandom), tile_pool[$urandom_range(0, 3)]}), 1'b0, '0);
        end
        if (at_addr != nt_addr && (!vram_ok[at_addr] || $urandom_range(0, 7) == 0)) begin
            send_beat(junk_beat(OP_MEM_WR, 14'(at_addr), $urandom), 1'b0, '0);
        end
        pat_addr = (pth_q ? 'h1000 : 0) + 16 * int'(vram_q[nt_addr]);
        for (int k = 0; k < 16; k++) begin
            if (!vram_ok[pat_addr + k] || $urandom_range(0, 31) == 0) begin
                send_beat(junk_beat(OP_MEM_WR, 14'(pat_addr + k), $urandom), 1'b0, '0);
            end
        end
        pal_base = 4 * int'((vram_q[at_addr] >> at_shift) & 8'd3);
        for (int k = 0; k < 4; k++) begin
            idx = (k == 0) ? 0 : pal_base + k;
            if (!pal_ok[idx] || $urandom_range(0, 15) == 0) begin
                send_beat(junk_beat(OP_PAL_WR, 14'(idx), $urandom), 1'b0, '0);
            end
        end
        beat = junk_beat(OP_RENDER, 14'($urandom), $urandom);
        beat.nametable_select = sel;
        beat.tile_row         = row;
        beat.tile_column      = col;
        send_beat(beat, 1'b0, '0);
    endtask

    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            render_sequence();
        end else if (pick < 75) begin
            send_beat(junk_beat(OP_MEM_WR, 14'($urandom), $urandom), 1'b0, '0);
        end else if (pick < 92) begin
            send_beat(junk_beat(OP_PAL_WR, ($urandom_range(0, 3) == 0) ? 14'($urandom)
                                : 14'($urandom_range(0, PAL_DEPTH - 1)), $urandom), 1'b0, '0);
        end else begin
            send_beat(junk_beat(OP_UNUSED, 14'($urandom), $urandom), 1'b0, '0);
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (rx_hold_cycles - 1) @(negedge i_clk);
                rx_hold_cycles = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel beat %h", o_out);
                failed = 1'b1;
            end else begin
                pixel_want = pixel_q.pop_front();
                if (o_out.pixel_color !== pixel_want.pixel_color) begin
                    $error("pixel_color: expected %h, got %h",
                           pixel_want.pixel_color, o_out.pixel_color);
                    failed = 1'b1;
                end
                if (o_out.pixel_x !== pixel_want.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", pixel_want.pixel_x, o_out.pixel_x);
                    failed = 1'b1;
                end
                if (o_out.pixel_y !== pixel_want.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", pixel_want.pixel_y, o_out.pixel_y);
                    failed = 1'b1;
                end
                if (o_out.last_pixel !== pixel_want.last_pixel) begin
                    $error("last_pixel: expected %0d, got %0d",
                           pixel_want.last_pixel, o_out.last_pixel);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        t_ntr_in beat;
        int target;

        // tile 0xFF, low plane all ones: colour code 1 on every pixel
        directed_steps = '{
            row_beat(OP_PAL_WR, 14'd0,     32'h0000_0000, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_PAL_WR, 14'd1,     32'hFFFF_FFFF, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_PAL_WR, 14'd12,    32'h1234_5678, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_PAL_WR, 14'd13,    32'hFF00_FF00, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_PAL_WR, 14'd14,    32'h00FF_00FF, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_PAL_WR, 14'd15,    32'h8000_0001, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_PAL_WR, 14'h3FFF,  32'hDEAD_BEEF, 2'd3, 5'd31, 5'd31, 5'd1, 1'b0, '0),
            row_beat(OP_UNUSED, 14'h3FFF,  32'hFFFF_FFFF, 2'd3, 5'd31, 5'd31, 5'd1, 1'b0, '0),
            row_beat(OP_MEM_WR, 14'h2FFF,  32'hFFFF_FFFF, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_MEM_WR, 14'h2000,  32'hFFFF_FFFF, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_MEM_WR, 14'h23C0,  32'hFFFF_FF00, 2'd0, 5'd0,  5'd0,  5'd1, 1'b0, '0),
            row_beat(OP_MEM_WR, 14'h0FF0,  32'h0000_00FF, 2'd0, 5'd0,  5'd0,  5'd8, 1'b0, '0),
            row_beat(OP_MEM_WR, 14'h0FF8,  32'hFFFF_FF00, 2'd0, 5'd0,  5'd0,  5'd8, 1'b0, '0),
            row_beat(OP_RENDER, 14'd0,     32'h0000_0000, 2'd0, 5'd0,  5'd0,  5'd1,
                     1'b1, 32'hFFFF_FFFF),
            row_beat(OP_RENDER, 14'h3FFF,  32'hFFFF_FFFF, 2'd3, 5'd31, 5'd31, 5'd1,
                     1'b1, 32'hFF00_FF00),
            row_cfg(CFG_DISPLAY_MODE, MODE_GRAY),
            row_beat(OP_RENDER, 14'h3FFF,  32'hFFFF_FFFF, 2'd3, 5'd31, 5'd31, 5'd1,
                     1'b1, 32'hFF80_8080),
            row_cfg(CFG_DISPLAY_MODE, MODE_ATTR),
            row_beat(OP_RENDER, 14'h1555,  32'h5555_AAAA, 2'd3, 5'd31, 5'd31, 5'd1, 1'b0, '0),
            row_cfg(CFG_DISPLAY_MODE, MODE_SPARE),
            row_beat(OP_RENDER, 14'h2AAA,  32'hAAAA_5555, 2'd0, 5'd0,  5'd0,  5'd1,
                     1'b1, 32'hFFFF_FFFF),
            row_cfg(CFG_DISPLAY_MODE, MODE_NORMAL)
        };
        tile_pool = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[s]) begin
            if (directed_steps[s].is_cfg) begin
                write_cfg(directed_steps[s].cfg_index, directed_steps[s].cfg_value);
            end else begin
                for (int k = 0; k < int'(directed_steps[s].count); k++) begin
                    beat = directed_steps[s].beat;
                    beat.address = beat.address + 14'(k);
                    send_beat(beat, directed_steps[s].typed, directed_steps[s].color);
                end
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            quiet = (phase == NUM_PHASES - 1);
            write_cfg(CFG_DISPLAY_MODE, PHASE_MODE[phase]);
            write_cfg(CFG_PATTERN_HIGH, {1'($urandom), PHASE_PTH[phase]});
            if (phase == 1) begin
                rx_hold_cycles = HOLD_CYCLES;
            end
            target = beats_taken + PHASE_BEATS;
            while (beats_taken < target) random_step();
        end

        settle();
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
